// File: rtl/core/ksa_pkg.sv
// Shared types, constants and a helper function for the keyframe sine animator.
package ksa_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] CFG_RANGE  = 3'd0;
  localparam logic [2:0] CFG_OFFSET = 3'd1;
  localparam logic [2:0] CFG_RATE   = 3'd2;
  localparam logic [2:0] CFG_REPEAT = 3'd3;
  localparam logic [2:0] CFG_STARTX = 3'd4;
  localparam logic [2:0] CFG_STARTY = 3'd5;
  localparam logic [2:0] CFG_STARTZ = 3'd6;

  localparam int DIV_W   = 48;
  localparam int DSR_W   = 32;
  localparam int TURN_UNITS = 92160;
  localparam int TURN_HALF  = 46080;
  localparam int MOD_BASE   = 45;
  localparam int ANG_BIAS   = 1474560;
  localparam int RECIP45    = 5965232;
  localparam int RECIP_SHIFT = 28;
  localparam int FRAC_ONE   = 65536;
  localparam int FRAC_LIMIT = 16777216;
  localparam int Q30_ONE    = 1073741824;
  localparam int SINE_SEED  = 172272;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [32:0] sine_coef(input logic [1:0] k);
    logic signed [32:0] c;
    case (k)
      2'd0:    c = -33'sd5026995;
      2'd1:    c = 33'sd85569306;
      2'd2:    c = -33'sd693598668;
      default: c = 33'sd1686629713;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/keyframe_sine_animator_core.sv
// Top level of the keyframe sine animator: control sequencer, keyframe memories and datapath.
// Add, clear, unknown and done-tick requests go from acceptance straight to S_DONE, which
// registers their result. An interpolating tick reads keys in S_RD and S_CMP up to the match,
// then runs S_FRAC, the fraction division, reduction, sine and scaling per axis, S_END and S_DONE.
// A tick past every stored key time reads all stored keys, then goes to S_END. One request at a time:
// the next is accepted in the cycle after the result is loaded. Reset clears the sequencer state.
module keyframe_sine_animator_core
  import ksa_pkg::*;
#(
  parameter int MAX_KEYS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [23:0]        elapsed,
  input  logic [31:0]        key_time,
  input  logic signed [19:0] key_x,
  input  logic signed [19:0] key_y,
  input  logic signed [19:0] key_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               finished,
  output logic               table_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int VW = 17 + IW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_TIME, S_RD, S_CMP, S_FRAC, S_FDIV, S_AX, S_ANG, S_MOD1, S_MOD2,
    S_IDX1, S_IDX2, S_IDX3, S_SIN, S_SCALE, S_END, S_DONE
  } state_t;

  state_t             state;
  logic signed [31:0] swing_range;
  logic signed [31:0] swing_offset;
  logic [15:0]        rate_scale;
  logic               repeat_mode;
  logic signed [19:0] start_x, start_y, start_z;

  logic [31:0]        clock_time;
  logic               done_flag;
  logic [31:0]        last_key_time;
  logic [CW-1:0]      entry_count;
  logic [59:0]        last_a;
  logic signed [31:0] held [3];
  logic               full;

  logic [31:0]        step;
  logic [KW-1:0]      idx;
  logic [31:0]        prev_t, cur_t;
  logic [59:0]        prev_a, cur_a;
  logic               frac_neg;
  logic signed [25:0] frac;
  logic [1:0]         ax;
  logic signed [46:0] prod_a;
  logic signed [31:0] ang;
  logic [21:0]        hp;
  logic [10:0]        lo11;
  logic [44:0]        qm;
  logic [16:0]        m;
  logic [31:0]        phase;
  logic signed [63:0] prod_s;

  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic               sin_start;
  logic               sin_done;
  logic signed [31:0] sin_val;

  logic               ram_we;
  logic               ram_re;
  logic [31:0]        rd_time;
  logic [59:0]        rd_ang;

  logic [32:0]        sum;
  logic signed [32:0] num, den;
  logic [32:0]        num_mag, den_mag;
  logic [24:0]        qc;
  logic signed [19:0] a1, a0;
  logic signed [20:0] d;
  logic signed [47:0] rnd;
  logic [21:0]        hp_c;
  logic [16:0]        q45;
  logic [21:0]        r45;
  logic [VW-1:0]      v;
  logic [IW:0]        qq;
  logic [IW-1:0]      sidx;
  logic signed [32:0] sc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign ram_we    = (state == S_IDLE) && in_valid && (command == CMD_ADD) &&
                     (entry_count < CW'(MAX_KEYS));
  assign ram_re    = (state == S_RD);

  ksa_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk(clk), .we(ram_we), .waddr(entry_count[KW-1:0]), .wdata(key_time),
    .re(ram_re), .raddr(idx), .rdata(rd_time)
  );

  ksa_ram #(.WIDTH(60), .DEPTH(MAX_KEYS)) u_angle_ram (
    .clk(clk), .we(ram_we), .waddr(entry_count[KW-1:0]), .wdata({key_z, key_y, key_x}),
    .re(ram_re), .raddr(idx), .rdata(rd_ang)
  );

  ksa_divider u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(div_quot)
  );

  ksa_sine u_sine (
    .clk(clk), .rst(rst), .start(sin_start), .phase(phase), .done(sin_done), .sine(sin_val)
  );

  always_comb begin
    sum     = {1'b0, clock_time} + {1'b0, step};
    num     = $signed({1'b0, clock_time}) - $signed({1'b0, prev_t});
    den     = $signed({1'b0, cur_t}) - $signed({1'b0, prev_t});
    num_mag = num[32] ? 33'(-num) : 33'(num);
    den_mag = den[32] ? 33'(-den) : 33'(den);
    qc      = (div_quot > DIV_W'(FRAC_LIMIT)) ? 25'(FRAC_LIMIT) : div_quot[24:0];
    case (ax)
      2'd0:    begin a1 = cur_a[19:0];  a0 = prev_a[19:0];  end
      2'd1:    begin a1 = cur_a[39:20]; a0 = prev_a[39:20]; end
      default: begin a1 = cur_a[59:40]; a0 = prev_a[59:40]; end
    endcase
    d    = 21'(a1) - 21'(a0);
    rnd  = 48'(prod_a) + 48'sd32768;
    hp_c = 22'(ang >>> 11) + 22'(ANG_BIAS);
    q45  = qm[RECIP_SHIFT+16:RECIP_SHIFT];
    r45  = hp - 22'(q45) * 22'(MOD_BASE);
    v    = VW'(m) * VW'(SINE_TABLE_DEPTH) + VW'(TURN_HALF);
    qq   = (r45 >= 22'(MOD_BASE)) ? (IW+1)'(q45) + (IW+1)'(1) : (IW+1)'(q45);
    sidx = (qq >= (IW+1)'(SINE_TABLE_DEPTH)) ? IW'(qq - (IW+1)'(SINE_TABLE_DEPTH))
                                             : qq[IW-1:0];
    sc   = 33'(swing_offset) + 33'((prod_s + 64'sd1073741824) >>> 31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swing_range  <= 32'sd131072;
      swing_offset <= '0;
      rate_scale   <= 16'd256;
      repeat_mode  <= 1'b0;
      start_x      <= '0;
      start_y      <= '0;
      start_z      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RANGE:  swing_range  <= cfg_data;
        CFG_OFFSET: swing_offset <= cfg_data;
        CFG_RATE:   rate_scale   <= cfg_data[15:0];
        CFG_REPEAT: repeat_mode  <= cfg_data[0];
        CFG_STARTX: start_x      <= cfg_data[19:0];
        CFG_STARTY: start_y      <= cfg_data[19:0];
        CFG_STARTZ: start_z      <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      clock_time    <= '0;
      done_flag     <= 1'b0;
      last_key_time <= '0;
      entry_count   <= '0;
      held[0]       <= '0;
      held[1]       <= '0;
      held[2]       <= '0;
      out_valid     <= 1'b0;
      div_req       <= '0;
      sin_start     <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      sin_start     <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            full  <= 1'b0;
            state <= S_DONE;
            case (cmd_t'(command))
              CMD_TICK: begin
                step <= 32'((40'(elapsed) * 40'(rate_scale)) >> 8);
                if (!done_flag) begin
                  state <= S_TIME;
                end
              end
              CMD_ADD: begin
                if (entry_count < CW'(MAX_KEYS)) begin
                  entry_count <= entry_count + CW'(1);
                  last_a      <= {key_z, key_y, key_x};
                  if (key_time > last_key_time) begin
                    last_key_time <= key_time;
                  end
                end else begin
                  full <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                entry_count   <= '0;
                clock_time    <= '0;
                done_flag     <= 1'b0;
                last_key_time <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_TIME: begin
          clock_time <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          idx        <= '0;
          prev_t     <= '0;
          prev_a     <= {start_z, start_y, start_x};
          state      <= (entry_count == '0) ? S_END : S_RD;
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_time >= clock_time) begin
            cur_t <= rd_time;
            cur_a <= rd_ang;
            state <= S_FRAC;
          end else begin
            prev_t <= rd_time;
            prev_a <= rd_ang;
            if (idx == KW'(entry_count - CW'(1))) begin
              state <= S_END;
            end else begin
              idx   <= idx + KW'(1);
              state <= S_RD;
            end
          end
        end
        S_FRAC: begin
          ax <= 2'd0;
          if (den == '0) begin
            frac  <= 26'sd65536;
            state <= S_AX;
          end else begin
            frac_neg         <= num[32] ^ den[32];
            div_req.start    <= 1'b1;
            div_req.dividend <= {num_mag[31:0], 16'd0};
            div_req.divisor  <= den_mag[31:0];
            state            <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            frac  <= frac_neg ? -26'(qc) : 26'(qc);
            state <= S_AX;
          end
        end
        S_AX: begin
          prod_a <= 47'(d) * 47'(frac);
          state  <= S_ANG;
        end
        S_ANG: begin
          ang   <= 32'(rnd >>> 16) + 32'(a0);
          state <= S_MOD1;
        end
        S_MOD1: begin
          hp    <= hp_c;
          lo11  <= ang[10:0];
          qm    <= 45'(hp_c) * 45'(RECIP45);
          state <= S_MOD2;
        end
        S_MOD2: begin
          m     <= (r45 >= 22'(MOD_BASE)) ? {6'(r45 - 22'(MOD_BASE)), lo11}
                                          : {r45[5:0], lo11};
          state <= S_IDX1;
        end
        S_IDX1: begin
          hp    <= 22'(v >> 11);
          state <= S_IDX2;
        end
        S_IDX2: begin
          qm    <= 45'(hp) * 45'(RECIP45);
          state <= S_IDX3;
        end
        S_IDX3: begin
          phase     <= 32'(sidx) << (32 - IW);
          sin_start <= 1'b1;
          state     <= S_SIN;
        end
        S_SIN: begin
          if (sin_done) begin
            prod_s <= 64'(sin_val) * 64'(swing_range);
            state  <= S_SCALE;
          end
        end
        S_SCALE: begin
          case (ax)
            2'd0:    held[0] <= (sc > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                                (sc < -33'sd2147483648) ? 32'sh8000_0000 : 32'(sc);
            2'd1:    held[1] <= (sc > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                                (sc < -33'sd2147483648) ? 32'sh8000_0000 : 32'(sc);
            default: held[2] <= (sc > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                                (sc < -33'sd2147483648) ? 32'sh8000_0000 : 32'(sc);
          endcase
          if (ax == 2'd2) begin
            state <= S_END;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_AX;
          end
        end
        S_END: begin
          if (entry_count != '0 && clock_time >= last_key_time) begin
            held[0] <= $signed({{4{last_a[19]}}, last_a[19:0], 8'd0});
            held[1] <= $signed({{4{last_a[39]}}, last_a[39:20], 8'd0});
            held[2] <= $signed({{4{last_a[59]}}, last_a[59:40], 8'd0});
          end
          if (clock_time >= last_key_time) begin
            if (repeat_mode) begin
              clock_time <= '0;
            end else begin
              done_flag <= 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_x      <= held[0];
            out_y      <= held[1];
            out_z      <= held[2];
            finished   <= done_flag;
            table_full <= full;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_KEYS))
    else $error("keyframe count beyond table size");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_RD)
    else $error("compare without a preceding memory read");

  a_frac_clamp: assert property (@(posedge clk) disable iff (rst)
    state == S_AX |-> (frac <= 26'sd16777216 && frac >= -26'sd16777216))
    else $error("interpolation fraction outside clamp range");

endmodule

// File: rtl/core/ksa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ksa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ksa_divider.sv
// Unsigned restoring divider that produces one quotient bit per cycle.
module ksa_divider
  import ksa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, quotient[DIV_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quotient <= req.dividend;
        dsr      <= req.divisor;
        rem      <= '0;
        cnt      <= CNT_W'(DIV_W);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
        quotient <= {quotient[DIV_W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/ksa_sine.sv
// Sequential Q30 sine evaluator using an odd degree-9 polynomial on one multiplier.
module ksa_sine
  import ksa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] sine
);

  typedef enum logic [2:0] {
    S_IDLE, S_X2, S_X2W, S_MUL, S_ADD, S_LAST, S_FIN
  } state_t;

  state_t             state;
  logic [1:0]         quad;
  logic [30:0]        x;
  logic signed [31:0] x2;
  logic signed [32:0] t;
  logic [1:0]         k;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic signed [32:0] tf;

  always_comb begin
    mul_a = 33'(signed'({2'b00, x}));
    mul_b = 32'(signed'({1'b0, x}));
    case (state)
      S_MUL: begin
        mul_a = t;
        mul_b = x2;
      end
      S_LAST: begin
        mul_a = t;
      end
      default: begin
      end
    endcase
    tf = 33'(prod >>> 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            quad  <= phase[31:30];
            x     <= phase[30] ? 31'(Q30_ONE) - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
            state <= S_X2;
          end
        end
        S_X2: begin
          prod  <= 65'(mul_a) * 65'(mul_b);
          state <= S_X2W;
        end
        S_X2W: begin
          x2    <= 32'(prod >>> 30);
          t     <= 33'sd172272;
          k     <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 65'(mul_a) * 65'(mul_b);
          state <= S_ADD;
        end
        S_ADD: begin
          t <= sine_coef(k) + tf;
          if (k == 2'd3) begin
            state <= S_LAST;
          end else begin
            k     <= k + 2'd1;
            state <= S_MUL;
          end
        end
        S_LAST: begin
          prod  <= 65'(mul_a) * 65'(mul_b);
          state <= S_FIN;
        end
        S_FIN: begin
          if (tf > 33'(Q30_ONE)) begin
            sine <= quad[1] ? -32'(Q30_ONE) : 32'(Q30_ONE);
          end else if (tf < 0) begin
            sine <= '0;
          end else begin
            sine <= quad[1] ? -32'(tf) : 32'(tf);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (sine <= 32'sd1073741824 && sine >= -32'sd1073741824))
    else $error("sine result outside of unit range");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("sine started while busy");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the keyframe sine animator core with a built-in motion predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ksa_pkg::*;

  localparam int NKEYS = 16;
  localparam int DEPTH = 1024;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [23:0]        dt;
    logic [31:0]        kt;
    logic signed [19:0] kx;
    logic signed [19:0] ky;
    logic signed [19:0] kz;
  } motion_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               fin;
    logic               full;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_taken = 1'b0;
  logic [1:0] command = '0;
  logic [23:0] elapsed = '0;
  logic [31:0] key_time = '0;
  logic signed [19:0] key_x = '0, key_y = '0, key_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic finished, table_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  keyframe_sine_animator_core uut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic signed [31:0] p_range, p_offset;
  logic [15:0] p_rate;
  logic p_repeat;
  logic signed [19:0] p_start [3];
  logic [31:0] p_timer, p_last;
  logic p_done;
  int p_count;
  logic [31:0] p_times [NKEYS];
  logic signed [19:0] p_angles [NKEYS][3];
  logic signed [31:0] p_held [3];

  motion_req_t pending_reqs[$];
  pose_t expected_poses[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sine_of(int idx);
    longint u, r, x, x2, t;
    int quad;
    u = (longint'(idx) << 32) / DEPTH;
    quad = int'(u >> 30) & 3;
    r = u & 64'h3FFF_FFFF;
    x = (quad & 1) ? (64'sd1073741824 - r) : r;
    x2 = fshift(x * x, 30);
    t = 172272;
    t = -5026995 + fshift(t * x2, 30);
    t = 85569306 + fshift(t * x2, 30);
    t = -693598668 + fshift(t * x2, 30);
    t = 1686629713 + fshift(t * x2, 30);
    t = fshift(t * x, 30);
    if (t > 64'sd1073741824) t = 64'sd1073741824;
    if (t < 0) t = 0;
    return (quad & 2) ? -t : t;
  endfunction

  function automatic logic signed [31:0] shape(longint ang);
    longint m, idx, v;
    m = ang % 92160;
    if (m < 0) m += 92160;
    idx = (m * DEPTH + 46080) / 92160;
    if (idx >= DEPTH) idx -= DEPTH;
    v = longint'(p_offset) + fshift(sine_of(int'(idx)) * longint'(p_range) + 64'sd1073741824, 31);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic queue_req(input motion_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic advance_motion(input logic [23:0] dt);
    longint s, t0, num, den, frac, d, ang;
    logic signed [19:0] a0 [3];
    s = longint'(p_timer) + ((longint'(dt) * longint'(p_rate)) >> 8);
    p_timer = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    for (int i = 0; i < p_count; i++) begin
      if (p_times[i] >= p_timer) begin
        t0 = 0;
        for (int k = 0; k < 3; k++) a0[k] = (i == 0) ? p_start[k] : p_angles[i-1][k];
        if (i != 0) t0 = longint'(p_times[i-1]);
        num = longint'(p_timer) - t0;
        den = longint'(p_times[i]) - t0;
        frac = (den == 0) ? 65536 : (num * 65536) / den;
        if (frac > 16777216) frac = 16777216;
        if (frac < -16777216) frac = -16777216;
        for (int k = 0; k < 3; k++) begin
          d = longint'(p_angles[i][k]) - longint'(a0[k]);
          ang = longint'(a0[k]) + fshift(d * frac + 32768, 16);
          p_held[k] = shape(ang);
        end
        break;
      end
    end
    if (p_count != 0 && p_timer >= p_last)
      for (int k = 0; k < 3; k++) p_held[k] = {{4{p_angles[p_count-1][k][19]}}, p_angles[p_count-1][k], 8'd0};
    if (p_timer >= p_last) begin
      if (p_repeat) p_timer = '0;
      else p_done = 1'b1;
    end
  endtask

  task automatic predict_pose(input motion_req_t r);
    pose_t e;
    e.full = 1'b0;
    case (cmd_t'(r.cmd))
      CMD_TICK: if (!p_done) advance_motion(r.dt);
      CMD_ADD: begin
        if (p_count < NKEYS) begin
          p_times[p_count] = r.kt;
          p_angles[p_count][0] = r.kx;
          p_angles[p_count][1] = r.ky;
          p_angles[p_count][2] = r.kz;
          p_count++;
          if (r.kt > p_last) p_last = r.kt;
        end else begin
          e.full = 1'b1;
        end
      end
      CMD_CLEAR: begin
        p_count = 0;
        p_timer = '0;
        p_done = 1'b0;
        p_last = '0;
      end
      default: ;
    endcase
    e.x = p_held[0];
    e.y = p_held[1];
    e.z = p_held[2];
    e.fin = p_done;
    expected_poses = {expected_poses, e};
  endtask

  function automatic motion_req_t make_req(logic [1:0] c, logic [23:0] dt, logic [31:0] kt,
                                           logic [19:0] kx, logic [19:0] ky, logic [19:0] kz);
    motion_req_t r;
    r.cmd = c; r.dt = dt; r.kt = kt; r.kx = kx; r.ky = ky; r.kz = kz;
    return r;
  endfunction

  function automatic logic [19:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 20'h80000 | 20'($urandom);
      1: return 20'($urandom);
      default: return 20'($urandom_range(0, 46080 * 2)) - 20'd46080;
    endcase
  endfunction

  function automatic motion_req_t rand_add(logic [31:0] kt);
    return make_req(CMD_ADD, 24'($urandom), kt, rand_angle(), rand_angle(), rand_angle());
  endfunction

  function automatic motion_req_t rand_tick();
    logic [23:0] dt;
    case ($urandom_range(0, 9))
      0: dt = 24'($urandom);
      1: dt = 24'hFFFFFF;
      default: dt = 24'($urandom_range(0, 24'h3FFFF));
    endcase
    return make_req(CMD_TICK, dt, $urandom, 20'($urandom), 20'($urandom), 20'($urandom));
  endfunction

  // Driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          motion_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          command <= r.cmd; elapsed <= r.dt; key_time <= r.kt;
          key_x <= r.kx; key_y <= r.ky; key_z <= r.kz;
          predict_pose(r);
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 22);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          pose_t e;
          e = expected_poses.pop_front();
          if (out_x !== e.x) begin $error("out_x exp %0d got %0d", e.x, out_x); errors++; end
          if (out_y !== e.y) begin $error("out_y exp %0d got %0d", e.y, out_y); errors++; end
          if (out_z !== e.z) begin $error("out_z exp %0d got %0d", e.z, out_z); errors++; end
          if (finished !== e.fin) begin
            $error("finished exp %0d got %0d", e.fin, finished); errors++;
          end
          if (table_full !== e.full) begin
            $error("table_full exp %0d got %0d", e.full, table_full); errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RANGE:  p_range = val;
      CFG_OFFSET: p_offset = val;
      CFG_RATE:   p_rate = val[15:0];
      CFG_REPEAT: p_repeat = val[0];
      CFG_STARTX: p_start[0] = val[19:0];
      CFG_STARTY: p_start[1] = val[19:0];
      CFG_STARTZ: p_start[2] = val[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_poses.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_phase(input int n);
    int keys;
    logic [31:0] t;
    queue_req(make_req(CMD_CLEAR, '0, '0, '0, '0, '0));
    while (n > 0) begin
      keys = $urandom_range(1, 6);
      t = 0;
      for (int i = 0; i < keys; i++) begin
        if ($urandom_range(0, 9) == 0) t = $urandom;
        else t = t + $urandom_range(0, 32'h40000);
        queue_req(rand_add(t));
      end
      for (int i = 0; i < $urandom_range(3, 10); i++) queue_req(rand_tick());
      if ($urandom_range(0, 9) == 0)
        queue_req(make_req(CMD_NONE, 24'($urandom), $urandom, 20'($urandom), 20'($urandom),
                           20'($urandom)));
      queue_req(make_req(CMD_CLEAR, 24'($urandom), $urandom, 20'($urandom), 20'($urandom),
                         20'($urandom)));
      n -= keys + 6;
    end
  endtask

  initial begin
    p_range = 131072; p_offset = 0; p_rate = 256; p_repeat = 1'b0;
    for (int k = 0; k < 3; k++) begin p_start[k] = '0; p_held[k] = '0; end
    p_timer = '0; p_last = '0; p_done = 1'b0; p_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a tick on an empty table, overfilling, extremes, unknown command.
    queue_req(make_req(CMD_TICK, 24'hFFFFFF, '0, '0, '0, '0));
    queue_req(make_req(CMD_CLEAR, '0, '0, '0, '0, '0));
    queue_req(make_req(CMD_ADD, '0, 32'h0, 20'h7FFFF, 20'h80000, 20'h0));
    queue_req(make_req(CMD_ADD, '0, 32'h0, 20'h0, 20'h7FFFF, 20'h80000));
    for (int i = 2; i < NKEYS; i++)
      queue_req(make_req(CMD_ADD, '0, 32'h10000 * i, 20'(20'h2D00 * i), 20'hFFFFF, 20'h1));
    queue_req(make_req(CMD_ADD, '0, 32'hFFFFFFFF, 20'h1, 20'h1, 20'h1));
    queue_req(make_req(CMD_TICK, 24'h8000, '0, '0, '0, '0));
    queue_req(make_req(CMD_NONE, 24'hFFFFFF, '1, '1, '1, '1));
    queue_req(make_req(CMD_TICK, 24'hFFFFFF, '0, '0, '0, '0));
    queue_req(make_req(CMD_TICK, 24'hFFFFFF, '0, '0, '0, '0));
    drain();

    write_reg(CFG_RANGE, 32'h7FFFFFFF);
    write_reg(CFG_OFFSET, 32'h80000000);
    write_reg(CFG_RATE, 32'hFFFF);
    write_reg(CFG_REPEAT, 32'd1);
    write_reg(CFG_STARTX, 32'h7FFFF);
    write_reg(CFG_STARTY, 32'hFFF80000);
    write_reg(CFG_STARTZ, 32'd23040);
    queue_req(make_req(CMD_CLEAR, '0, '0, '0, '0, '0));
    queue_req(make_req(CMD_ADD, '0, 32'h0, 20'h0, 20'h0, 20'h0));
    queue_req(make_req(CMD_ADD, '0, 32'h30000, 20'd46080, 20'd23040, 20'h80000));
    queue_req(make_req(CMD_TICK, 24'h100, '0, '0, '0, '0));
    queue_req(make_req(CMD_TICK, 24'h0, '0, '0, '0, '0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      write_reg(CFG_RANGE, (ph == 1) ? 32'h80000000 : $urandom);
      write_reg(CFG_OFFSET, (ph == 2) ? 32'h7FFFFFFF : $urandom_range(0, 32'h3FFFF) - 32'h20000);
      write_reg(CFG_RATE, (ph == 4) ? 32'd0 : $urandom_range(0, 16'hFFFF));
      write_reg(CFG_REPEAT, $urandom_range(0, 1));
      write_reg(CFG_STARTX, $urandom);
      write_reg(CFG_STARTY, $urandom);
      write_reg(CFG_STARTZ, $urandom);
      load_phase(40);
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
